FILE: rtl/core/cmtf_pkg.sv
package cmtf_pkg;

  localparam int Contexts   = 256;
  localparam int Window     = 32;
  localparam int ChaseLimit = 32;

  localparam int CtxW   = (Contexts > 1) ? $clog2(Contexts) : 1;
  localparam int RankW  = $clog2(Window);
  localparam int StepW  = $clog2(ChaseLimit + 1);
  localparam int HalfW  = Window / 2;

  localparam logic OpRaw  = 1'b0;
  localparam logic OpPred = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] context_req;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       stuck;
  } out_item_t;

  typedef logic [Window-1:0][7:0] window_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOOK,
    ST_CHASE,
    ST_WRITE,
    ST_OUT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_SWAP,
    UPD_INSERT
  } upd_kind_t;

  // controller to datapath
  typedef struct packed {
    logic      clear_wr;
    logic      load;
    logic      read_rec;
    logic      look;
    logic      chase_step;
    logic      write_rec;
    logic      out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic      clear_done;
    logic      chase_done;
    logic      is_raw_low;
  } dp_stat_t;

  // partner rank of the partial move-to-front swap
  function automatic logic [RankW-1:0] swap_partner(input logic [RankW-1:0] r);
    logic [RankW:0] s;
    s = {1'b0, r} + (RankW+1)'(3);
    return r - RankW'(s >> 2);
  endfunction

endpackage

FILE: rtl/core/cmtf_ctrl.sv
module cmtf_ctrl
  import cmtf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read_rec = 1'b1;
        state_next   = ST_LOOK;
      end
      ST_LOOK: begin
        cmd.look   = 1'b1;
        state_next = stat.is_raw_low ? ST_WRITE : ST_CHASE;
      end
      ST_CHASE: begin
        cmd.chase_step = 1'b1;
        if (stat.chase_done) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.write_rec = 1'b1;
        cmd.out_load  = 1'b1;
        state_next    = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> in_stall && !out_valid)
    else $error("transfer allowed during clearing pass");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_stall) |=> state == ST_OUT)
    else $error("result dropped while stalled");
  a_load_once: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_READ)
    else $error("load without read");

endmodule

FILE: rtl/core/cmtf_dp.sv
module cmtf_dp
  import cmtf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_item_t out_item
);

  // one row per context: the whole window plus its presence map
  window_t      rank_mem [Contexts];
  logic [255:0] pres_mem [Contexts];

  logic [CtxW-1:0] clr_idx;
  logic            clear_done;

  in_item_t        req;
  logic [CtxW-1:0] ctx;
  window_t         win;
  logic [255:0]    pres;
  logic [7:0]      cand;
  logic [StepW-1:0] steps;
  logic            done;
  upd_kind_t       kind;
  logic [RankW-1:0] hit_rank;
  logic            stuck;
  logic [7:0]      result;
  window_t         win_new;
  logic [255:0]    pres_new;

  // lowest rank holding the candidate
  logic            found;
  logic [RankW-1:0] found_rank;
  always_comb begin
    found      = 1'b0;
    found_rank = '0;
    for (int i = Window - 1; i >= 0; i--) begin
      if (win[i] == cand) begin
        found      = 1'b1;
        found_rank = RankW'(i);
      end
    end
  end

  logic cand_present;
  assign cand_present = pres[cand];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      clear_done <= 1'b0;
    end else if (cmd.clear_wr && !clear_done) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == CtxW'(Contexts - 1)) clear_done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_wr && !clear_done) begin
      for (int i = 0; i < Window; i++) rank_mem[clr_idx][i] <= 8'(i);
      pres_mem[clr_idx] <= {224'b0, 32'hffff_ffff};
    end else if (cmd.write_rec && kind != UPD_NONE) begin
      rank_mem[ctx] <= win_new;
      pres_mem[ctx] <= pres_new;
    end
    if (cmd.read_rec) begin
      win  <= rank_mem[ctx];
      pres <= pres_mem[ctx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
      stuck <= 1'b0;
    end else begin
      if (cmd.load) begin
        req  <= in_item;
        ctx  <= (32'(in_item.context_req) >= Contexts) ? CtxW'(Contexts - 1)
                                                    : CtxW'(in_item.context_req);
        cand  <= in_item.value;
        steps <= '0;
        done  <= 1'b0;
        stuck <= 1'b0;
      end
      if (cmd.look) begin
        if (req.operation == OpRaw && req.value < 8'(Window)) begin
          result   <= win[req.value[RankW-1:0]];
          hit_rank <= req.value[RankW-1:0];
          kind     <= UPD_SWAP;
        end else if (req.operation == OpPred) begin
          result <= req.value;
          done   <= 1'b1;
          if (cand_present && found) begin
            hit_rank <= found_rank;
            kind     <= UPD_SWAP;
          end else begin
            kind <= UPD_INSERT;
          end
        end
      end
      // the cap is checked before the window search, as long as the candidate is present
      if (cmd.chase_step && !done) begin
        if (!cand_present) begin
          done   <= 1'b1;
          kind   <= UPD_INSERT;
          result <= cand;
        end else if (steps >= StepW'(ChaseLimit)) begin
          done   <= 1'b1;
          kind   <= UPD_NONE;
          stuck  <= 1'b1;
          result <= '0;
        end else if (!found) begin
          done   <= 1'b1;
          kind   <= UPD_INSERT;
          result <= cand;
        end else begin
          cand  <= 8'(found_rank);
          steps <= steps + 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_item.symbol <= result;
        out_item.stuck  <= stuck;
      end
    end
  end

  always_comb begin
    logic [RankW-1:0] t;
    t        = swap_partner(hit_rank);
    win_new  = win;
    pres_new = pres;
    case (kind)
      UPD_SWAP: begin
        win_new[hit_rank] = win[t];
        win_new[t]        = win[hit_rank];
      end
      UPD_INSERT: begin
        pres_new[win[Window-1]] = 1'b0;
        pres_new[result]        = 1'b1;
        for (int i = HalfW + 1; i < Window; i++) win_new[i] = win[i-1];
        win_new[HalfW] = result;
      end
      default: ;
    endcase
  end

  assign stat.clear_done = clear_done;
  assign stat.chase_done = done;
  assign stat.is_raw_low = (req.operation == OpRaw) && (req.value < 8'(Window));

  a_stuck_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load && stuck |-> result == 8'd0)
    else $error("stuck result carries a symbol");
  a_steps_cap: assert property (@(posedge clk) disable iff (rst)
    steps <= StepW'(ChaseLimit))
    else $error("chase ran past its cap");
  a_stuck_no_write: assert property (@(posedge clk) disable iff (rst)
    cmd.write_rec && stuck |-> kind == UPD_NONE)
    else $error("stuck chase updated the window");

endmodule

FILE: rtl/core/context_mtf_window_update.sv
// Per-context move-to-front window: 256 order-1 contexts, each a 32-slot rank window and a
// 256-bit presence map held as one row. After reset the block runs a clearing pass (one
// context row a cycle, then a step to leave it) before it accepts an item. An item then
// passes through accept, row read, look-up, write-back and result when it is a raw code
// below 32; a predicted item adds a chase state, and a raw code of 32 or more adds chase
// steps through the window, one at a time, set by the single 32-wide compare unit. One
// item is handled at a time; a result waits until taken.
module context_mtf_window_update
  import cmtf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cmtf_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  cmtf_dp u_dp (
    .clk, .rst, .in_item(in_data), .cmd, .stat, .out_item(out_data)
  );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cmtf_pkg::*;

  localparam int NumRandom = 600;
  localparam int StallLimit = 20000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  bit failed;

  context_mtf_window_update dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  class mtf_scoreboard;
    logic [7:0]   ranks [Contexts][Window];
    logic [255:0] present [Contexts];
    out_item_t    pending [$];
    int           errors;

    function new();
      foreach (ranks[c]) begin
        foreach (ranks[c][i]) ranks[c][i] = 8'(i);
        present[c] = 256'hffff_ffff;
      end
      errors = 0;
    endfunction

    function int lowest_rank(int c, logic [7:0] s);
      for (int i = 0; i < Window; i++) begin
        if (ranks[c][i] == s) return i;
      end
      return Window;
    endfunction

    function void promote(int c, int r);
      int t;
      logic [7:0] a;
      t = r - ((r + 3) >> 2);
      a = ranks[c][r];
      ranks[c][r] = ranks[c][t];
      ranks[c][t] = a;
    endfunction

    function void admit(int c, logic [7:0] s);
      present[c][ranks[c][Window-1]] = 1'b0;
      present[c][s] = 1'b1;
      for (int i = Window - 1; i > HalfW; i--) ranks[c][i] = ranks[c][i-1];
      ranks[c][HalfW] = s;
    endfunction

    function void note_transfer(in_item_t it);
      out_item_t  res;
      int         c, r, steps;
      logic [7:0] cand;
      c = (int'(it.context_req) >= Contexts) ? Contexts - 1 : int'(it.context_req);
      res = '0;
      if (it.operation == OpRaw) begin
        if (it.value < Window) begin
          res.symbol = ranks[c][it.value];
          if (it.value != 0) promote(c, it.value);
        end else begin
          cand = it.value;
          steps = 0;
          forever begin
            if (!present[c][cand]) break;
            if (steps >= ChaseLimit) begin
              res.stuck = 1'b1;
              break;
            end
            r = lowest_rank(c, cand);
            if (r >= Window) break;
            cand = 8'(r);
            steps++;
          end
          if (!res.stuck) begin
            admit(c, cand);
            res.symbol = cand;
          end
        end
      end else begin
        r = present[c][it.value] ? lowest_rank(c, it.value) : Window;
        if (r < Window) begin
          if (r != 0) promote(c, r);
        end else begin
          admit(c, it.value);
        end
        res.symbol = it.value;
      end
      pending.push_back(res);
    endfunction

    function void check_transfer(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result symbol %0d stuck %0d", $time, got.symbol, got.stuck);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.symbol !== want.symbol) begin
        $display("%0t: symbol expected %0d actual %0d", $time, want.symbol, got.symbol);
        errors++;
      end
      if (got.stuck !== want.stuck) begin
        $display("%0t: stuck expected %0d actual %0d", $time, want.stuck, got.stuck);
        errors++;
      end
    endfunction
  endclass

  mtf_scoreboard board;
  int  idle_pct;
  int  quiet_cycles;
  bit  feeding_done;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // acceptance on both channels, sampled at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note_transfer(in_data);
      if (out_valid && !out_stall) board.check_transfer(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver stalls at random
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(logic op, logic [7:0] ctx, logic [7:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{operation: op, context_req: ctx, value: val};
    do @(posedge clk); while (in_stall);
  endtask

  // raw and predicted codes, mostly into a small set of contexts so chases build up history
  task automatic send_random();
    logic [7:0] ctx;
    int         pick;
    ctx = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    pick = $urandom_range(9);
    if (pick < 4) send_item(OpRaw, ctx, 8'($urandom_range(31)));
    else if (pick < 7) send_item(OpRaw, ctx, 8'($urandom));
    else if (pick < 8) send_item(OpPred, ctx, 8'($urandom_range(63)));
    else send_item(OpPred, ctx, 8'($urandom));
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    quiet_cycles = 0;
    idle_pct = 19;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // field extremes, both operations and chase cases
    send_item(OpRaw, 8'd0, 8'd0);
    send_item(OpRaw, 8'd0, 8'd31);
    send_item(OpRaw, 8'd255, 8'd1);
    send_item(OpRaw, 8'd255, 8'd255);
    send_item(OpRaw, 8'd1, 8'd32);
    send_item(OpRaw, 8'd1, 8'd5);
    send_item(OpPred, 8'd2, 8'd0);
    send_item(OpPred, 8'd2, 8'd31);
    send_item(OpPred, 8'd2, 8'd200);
    send_item(OpPred, 8'd2, 8'd200);
    send_item(OpPred, 8'd3, 8'd255);
    send_item(OpRaw, 8'd3, 8'd255);
    send_item(OpRaw, 8'd3, 8'd16);
    // swap small symbols in a window so they sit at ranks off their own value
    for (int i = 0; i < 6; i++) send_item(OpRaw, 8'd4, 8'd2);
    send_item(OpRaw, 8'd4, 8'd2);
    send_item(OpPred, 8'd128, 8'd170);
    send_item(OpRaw, 8'd127, 8'd85);

    for (int n = 0; n < NumRandom; n++) begin
      idle_pct = (n >= 200 && n < 320) ? 0 : 19;
      send_random();
    end
    in_valid <= 1'b0;
    idle_pct = 19;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
